// ----- src/elg_pkg.sv -----
package elg_pkg;

    localparam int WORD_BITS_DEF  = 64;
    localparam int DATA_BITS      = 64;
    localparam int CFG_INDEX_BITS = 2;
    localparam int PC_BITS        = 6;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS_P        = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GENERATOR_G      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PUBLIC_BETA      = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PRIVATE_EXPONENT = 2'd3;

    // microcode entry points and branch targets
    localparam logic [PC_BITS-1:0] PC_ENCRYPT   = 6'd0;
    localparam logic [PC_BITS-1:0] PC_DECRYPT   = 6'd5;
    localparam logic [PC_BITS-1:0] PC_SIGN      = 6'd11;
    localparam logic [PC_BITS-1:0] PC_EUCLID    = 6'd16;
    localparam logic [PC_BITS-1:0] PC_SIGN_FIN  = 6'd26;
    localparam logic [PC_BITS-1:0] PC_SIGN_ERR  = 6'd36;
    localparam logic [PC_BITS-1:0] PC_VERIFY    = 6'd38;
    localparam logic [PC_BITS-1:0] PC_VERIFY_END = 6'd44;

    typedef enum logic [1:0] {
        MODE_ENCRYPT,
        MODE_DECRYPT,
        MODE_SIGN,
        MODE_VERIFY
    } mode_t;

    typedef struct packed {
        mode_t                mode;
        logic [DATA_BITS-1:0] plain_value;
        logic [DATA_BITS-1:0] ephemeral_nonce;
        logic [DATA_BITS-1:0] first_part_in;
        logic [DATA_BITS-1:0] second_part_in;
    } item_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] first_part_out;
        logic [DATA_BITS-1:0] second_part_out;
        logic [DATA_BITS-1:0] recovered_value;
        logic                 signature_ok;
        logic                 nonce_error;
    } result_t;

    // datapath word selects; SEL_ZERO as destination writes nothing
    typedef enum logic [4:0] {
        SEL_P, SEL_Q, SEL_G, SEL_BETA, SEL_A,
        SEL_MSG, SEL_K, SEL_GAM, SEL_DEL,
        SEL_R0, SEL_R1, SEL_T0, SEL_T1, SEL_X, SEL_Y,
        SEL_ACC, SEL_BAS, SEL_QUO,
        SEL_FIRST, SEL_SECOND, SEL_REC,
        SEL_ZERO, SEL_ONE
    } sel_t;

    typedef enum logic [3:0] {
        DP_NOP, DP_LOAD, DP_MOV, DP_SUBM, DP_MUL, DP_DIV,
        DP_POWINIT, DP_ESHIFT, DP_SETOK, DP_SETERR
    } dp_op_t;

    typedef enum logic {
        MOD_P,
        MOD_Q
    } mod_t;

    typedef struct packed {
        logic   go;
        dp_op_t op;
        sel_t   a;
        sel_t   b;
        mod_t   modsel;
        sel_t   dst;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic e_msb;
        logic r1_zero;
        logic r0_ne1;
        logic q_lt2;
        logic gam_bad;
    } status_t;

    typedef enum logic [1:0] {
        UK_OP,
        UK_POW,
        UK_BR,
        UK_END
    } ukind_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_R1_ZERO,
        C_R0_NE1,
        C_Q_LT2,
        C_GAM_BAD
    } cond_t;

    typedef struct packed {
        ukind_t             kind;
        dp_op_t             op;
        sel_t               a;
        sel_t               b;
        mod_t               modsel;
        sel_t               dst;
        cond_t              cond;
        logic [PC_BITS-1:0] target;
    } uinst_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_WAIT,
        S_PW_RED,
        S_PW_INIT,
        S_PW_SQ,
        S_PW_SQW,
        S_PW_ML,
        S_PW_MLW,
        S_PW_SH,
        S_PW_MV
    } state_t;

    function automatic uinst_t u_op(input dp_op_t op, input sel_t a, input sel_t b,
                                    input mod_t m, input sel_t d);
        uinst_t u;
        u = '{kind: UK_OP, op: op, a: a, b: b, modsel: m, dst: d,
              cond: C_ALWAYS, target: '0};
        return u;
    endfunction

    // modular power: dst = a ^ b mod p
    function automatic uinst_t u_pow(input sel_t a, input sel_t b, input sel_t d);
        uinst_t u;
        u = '{kind: UK_POW, op: DP_NOP, a: a, b: b, modsel: MOD_P, dst: d,
              cond: C_ALWAYS, target: '0};
        return u;
    endfunction

    function automatic uinst_t u_br(input cond_t c, input logic [PC_BITS-1:0] t);
        uinst_t u;
        u = '{kind: UK_BR, op: DP_NOP, a: SEL_ZERO, b: SEL_ZERO, modsel: MOD_P,
              dst: SEL_ZERO, cond: c, target: t};
        return u;
    endfunction

    function automatic uinst_t u_end();
        uinst_t u;
        u = '{kind: UK_END, op: DP_NOP, a: SEL_ZERO, b: SEL_ZERO, modsel: MOD_P,
              dst: SEL_ZERO, cond: C_ALWAYS, target: '0};
        return u;
    endfunction

    // DIV leaves a mod b in dst and a / b in QUO
    function automatic uinst_t ucode(input logic [PC_BITS-1:0] pc);
        uinst_t u;
        case (pc)
            // encrypt
            6'd0:  u = u_pow(SEL_G, SEL_K, SEL_FIRST);
            6'd1:  u = u_pow(SEL_BETA, SEL_K, SEL_Y);
            6'd2:  u = u_op(DP_DIV, SEL_MSG, SEL_P, MOD_P, SEL_X);
            6'd3:  u = u_op(DP_MUL, SEL_X, SEL_Y, MOD_P, SEL_SECOND);
            6'd4:  u = u_end();
            // decrypt
            6'd5:  u = u_op(DP_DIV, SEL_A, SEL_Q, MOD_Q, SEL_T0);
            6'd6:  u = u_op(DP_SUBM, SEL_Q, SEL_T0, MOD_Q, SEL_T1);
            6'd7:  u = u_pow(SEL_GAM, SEL_T1, SEL_X);
            6'd8:  u = u_op(DP_DIV, SEL_DEL, SEL_P, MOD_P, SEL_T0);
            6'd9:  u = u_op(DP_MUL, SEL_X, SEL_T0, MOD_P, SEL_REC);
            6'd10: u = u_end();
            // sign: extended Euclid for k^-1 mod q first
            6'd11: u = u_br(C_Q_LT2, PC_SIGN_ERR);
            6'd12: u = u_op(DP_MOV, SEL_Q, SEL_ZERO, MOD_Q, SEL_R0);
            6'd13: u = u_op(DP_DIV, SEL_K, SEL_Q, MOD_Q, SEL_R1);
            6'd14: u = u_op(DP_MOV, SEL_ZERO, SEL_ZERO, MOD_Q, SEL_T0);
            6'd15: u = u_op(DP_MOV, SEL_ONE, SEL_ZERO, MOD_Q, SEL_T1);
            6'd16: u = u_br(C_R1_ZERO, PC_SIGN_FIN);
            6'd17: u = u_op(DP_DIV, SEL_R0, SEL_R1, MOD_Q, SEL_Y);
            6'd18: u = u_op(DP_DIV, SEL_QUO, SEL_Q, MOD_Q, SEL_X);
            6'd19: u = u_op(DP_MUL, SEL_X, SEL_T1, MOD_Q, SEL_X);
            6'd20: u = u_op(DP_SUBM, SEL_T0, SEL_X, MOD_Q, SEL_X);
            6'd21: u = u_op(DP_MOV, SEL_T1, SEL_ZERO, MOD_Q, SEL_T0);
            6'd22: u = u_op(DP_MOV, SEL_X, SEL_ZERO, MOD_Q, SEL_T1);
            6'd23: u = u_op(DP_MOV, SEL_R1, SEL_ZERO, MOD_Q, SEL_R0);
            6'd24: u = u_op(DP_MOV, SEL_Y, SEL_ZERO, MOD_Q, SEL_R1);
            6'd25: u = u_br(C_ALWAYS, PC_EUCLID);
            6'd26: u = u_br(C_R0_NE1, PC_SIGN_ERR);
            6'd27: u = u_pow(SEL_G, SEL_K, SEL_FIRST);
            6'd28: u = u_op(DP_DIV, SEL_A, SEL_Q, MOD_Q, SEL_X);
            6'd29: u = u_op(DP_DIV, SEL_FIRST, SEL_Q, MOD_Q, SEL_Y);
            6'd30: u = u_op(DP_MUL, SEL_X, SEL_Y, MOD_Q, SEL_Y);
            6'd31: u = u_op(DP_DIV, SEL_MSG, SEL_Q, MOD_Q, SEL_X);
            6'd32: u = u_op(DP_SUBM, SEL_X, SEL_Y, MOD_Q, SEL_X);
            6'd33: u = u_op(DP_MUL, SEL_X, SEL_T0, MOD_Q, SEL_SECOND);
            6'd34: u = u_end();
            6'd36: u = u_op(DP_SETERR, SEL_ZERO, SEL_ZERO, MOD_P, SEL_ZERO);
            6'd37: u = u_end();
            // verify
            6'd38: u = u_br(C_GAM_BAD, PC_VERIFY_END);
            6'd39: u = u_pow(SEL_BETA, SEL_GAM, SEL_X);
            6'd40: u = u_pow(SEL_GAM, SEL_DEL, SEL_Y);
            6'd41: u = u_op(DP_MUL, SEL_X, SEL_Y, MOD_P, SEL_X);
            6'd42: u = u_pow(SEL_G, SEL_MSG, SEL_Y);
            6'd43: u = u_op(DP_SETOK, SEL_ZERO, SEL_ZERO, MOD_P, SEL_ZERO);
            default: u = u_end();
        endcase
        return u;
    endfunction

    function automatic logic [PC_BITS-1:0] entry_pc(input mode_t m);
        logic [PC_BITS-1:0] pc;
        case (m)
            MODE_ENCRYPT: pc = PC_ENCRYPT;
            MODE_DECRYPT: pc = PC_DECRYPT;
            MODE_SIGN:    pc = PC_SIGN;
            MODE_VERIFY:  pc = PC_VERIFY;
            default:      pc = PC_ENCRYPT;
        endcase
        return pc;
    endfunction

endpackage

// ----- src/elg_modmul.sv -----
module elg_modmul #(
    parameter int W = elg_pkg::WORD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] prod
);

    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          phase_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  m_reg;

    logic [W-1:0]  addend;
    logic [W-1:0]  gap;
    logic [W-1:0]  sum;
    logic [W-1:0]  acc_next;

    // phase 0 doubles, phase 1 adds x when the multiplier bit is set
    always_comb
    begin
        addend   = phase_reg ? x_reg : acc_reg;
        gap      = m_reg - addend;
        sum      = (acc_reg >= gap) ? (acc_reg - gap) : (acc_reg + addend);
        acc_next = (!phase_reg || y_reg[W-1]) ? sum : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                cnt_reg   <= CW'(W - 1);
            end
            else if (busy_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            m_reg   <= m;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            if (phase_reg)
            begin
                y_reg <= {y_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign prod = (m_reg == '0) ? '0 : acc_reg;

endmodule

// ----- src/elg_divider.sv -----
module elg_divider #(
    parameter int W = elg_pkg::WORD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);

    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  n_reg;
    logic [W-1:0]  d_reg;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          fits;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        trial = {r_reg, n_reg[W-1]};
        diff  = trial - {1'b0, d_reg};
        fits  = ~diff[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            n_reg <= num;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            r_reg <= fits ? diff[W-1:0] : trial[W-1:0];
            n_reg <= {n_reg[W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = n_reg;
    // a zero modulus reduces everything to zero
    assign rem  = (d_reg == '0) ? '0 : r_reg;

endmodule

// ----- src/elg_datapath.sv -----
module elg_datapath #(
    parameter int W = elg_pkg::WORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [elg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [elg_pkg::DATA_BITS-1:0]        cfg_data,
    input  elg_pkg::item_t                       item,
    input  elg_pkg::cmd_t                        cmd,
    output elg_pkg::status_t                     status,
    output elg_pkg::result_t                     result
);

    logic [W-1:0] p_reg, q_reg, g_reg, beta_reg, a_reg;
    logic [W-1:0] msg_reg, k_reg, gam_reg, del_reg;
    logic [W-1:0] r0_reg, r1_reg, t0_reg, t1_reg, x_reg, y_reg;
    logic [W-1:0] acc_reg, bas_reg, quo_reg, e_reg;
    logic [W-1:0] first_reg, second_reg, rec_reg;
    logic         ok_reg, err_reg, quick_done_reg;
    elg_pkg::sel_t dst_reg;

    logic [W-1:0] opnd_a, opnd_b, mod_val, subm_val;
    logic [W-1:0] cfg_word;
    logic [W-1:0] mul_prod, div_quo, div_rem;
    logic         mul_done, div_done;
    logic         issue;
    logic         wr_en;
    elg_pkg::sel_t wr_sel;
    logic [W-1:0] wr_val;

    assign issue    = cmd.go;
    assign cfg_word = cfg_data[W-1:0];

    always_comb
    begin
        case (cmd.a)
            elg_pkg::SEL_P:      opnd_a = p_reg;
            elg_pkg::SEL_Q:      opnd_a = q_reg;
            elg_pkg::SEL_G:      opnd_a = g_reg;
            elg_pkg::SEL_BETA:   opnd_a = beta_reg;
            elg_pkg::SEL_A:      opnd_a = a_reg;
            elg_pkg::SEL_MSG:    opnd_a = msg_reg;
            elg_pkg::SEL_K:      opnd_a = k_reg;
            elg_pkg::SEL_GAM:    opnd_a = gam_reg;
            elg_pkg::SEL_DEL:    opnd_a = del_reg;
            elg_pkg::SEL_R0:     opnd_a = r0_reg;
            elg_pkg::SEL_R1:     opnd_a = r1_reg;
            elg_pkg::SEL_T0:     opnd_a = t0_reg;
            elg_pkg::SEL_T1:     opnd_a = t1_reg;
            elg_pkg::SEL_X:      opnd_a = x_reg;
            elg_pkg::SEL_Y:      opnd_a = y_reg;
            elg_pkg::SEL_ACC:    opnd_a = acc_reg;
            elg_pkg::SEL_BAS:    opnd_a = bas_reg;
            elg_pkg::SEL_QUO:    opnd_a = quo_reg;
            elg_pkg::SEL_FIRST:  opnd_a = first_reg;
            elg_pkg::SEL_SECOND: opnd_a = second_reg;
            elg_pkg::SEL_REC:    opnd_a = rec_reg;
            elg_pkg::SEL_ONE:    opnd_a = W'(1);
            default:             opnd_a = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.b)
            elg_pkg::SEL_P:      opnd_b = p_reg;
            elg_pkg::SEL_Q:      opnd_b = q_reg;
            elg_pkg::SEL_G:      opnd_b = g_reg;
            elg_pkg::SEL_BETA:   opnd_b = beta_reg;
            elg_pkg::SEL_A:      opnd_b = a_reg;
            elg_pkg::SEL_MSG:    opnd_b = msg_reg;
            elg_pkg::SEL_K:      opnd_b = k_reg;
            elg_pkg::SEL_GAM:    opnd_b = gam_reg;
            elg_pkg::SEL_DEL:    opnd_b = del_reg;
            elg_pkg::SEL_R0:     opnd_b = r0_reg;
            elg_pkg::SEL_R1:     opnd_b = r1_reg;
            elg_pkg::SEL_T0:     opnd_b = t0_reg;
            elg_pkg::SEL_T1:     opnd_b = t1_reg;
            elg_pkg::SEL_X:      opnd_b = x_reg;
            elg_pkg::SEL_Y:      opnd_b = y_reg;
            elg_pkg::SEL_ACC:    opnd_b = acc_reg;
            elg_pkg::SEL_BAS:    opnd_b = bas_reg;
            elg_pkg::SEL_QUO:    opnd_b = quo_reg;
            elg_pkg::SEL_FIRST:  opnd_b = first_reg;
            elg_pkg::SEL_SECOND: opnd_b = second_reg;
            elg_pkg::SEL_REC:    opnd_b = rec_reg;
            elg_pkg::SEL_ONE:    opnd_b = W'(1);
            default:             opnd_b = '0;
        endcase
    end

    always_comb
    begin
        mod_val  = (cmd.modsel == elg_pkg::MOD_Q) ? q_reg : p_reg;
        subm_val = (opnd_a >= opnd_b) ? (opnd_a - opnd_b) : (opnd_a + (mod_val - opnd_b));
    end

    elg_modmul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (issue && (cmd.op == elg_pkg::DP_MUL)),
        .x     (opnd_a),
        .y     (opnd_b),
        .m     (mod_val),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    elg_divider #(.W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (issue && (cmd.op == elg_pkg::DP_DIV)),
        .num   (opnd_a),
        .den   (opnd_b),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // one write port into the working words
    always_comb
    begin
        wr_en  = 1'b0;
        wr_sel = dst_reg;
        wr_val = '0;
        if (mul_done)
        begin
            wr_en  = 1'b1;
            wr_val = mul_prod;
        end
        else if (div_done)
        begin
            wr_en  = 1'b1;
            wr_val = div_rem;
        end
        else if (issue && (cmd.op == elg_pkg::DP_MOV))
        begin
            wr_en  = 1'b1;
            wr_sel = cmd.dst;
            wr_val = opnd_a;
        end
        else if (issue && (cmd.op == elg_pkg::DP_SUBM))
        begin
            wr_en  = 1'b1;
            wr_sel = cmd.dst;
            wr_val = subm_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg          <= W'(3);
            q_reg          <= W'(2);
            g_reg          <= W'(2);
            beta_reg       <= W'(1);
            a_reg          <= W'(1);
            ok_reg         <= 1'b0;
            err_reg        <= 1'b0;
            quick_done_reg <= 1'b0;
            dst_reg        <= elg_pkg::SEL_ZERO;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    elg_pkg::CFG_MODULUS_P:
                    begin
                        p_reg <= cfg_word;
                        q_reg <= cfg_word - 1'b1;
                    end
                    elg_pkg::CFG_GENERATOR_G:      g_reg    <= cfg_word;
                    elg_pkg::CFG_PUBLIC_BETA:      beta_reg <= cfg_word;
                    elg_pkg::CFG_PRIVATE_EXPONENT: a_reg    <= cfg_word;
                    default: ;
                endcase
            end
            quick_done_reg <= issue && ((cmd.op == elg_pkg::DP_MOV)
                                     || (cmd.op == elg_pkg::DP_SUBM)
                                     || (cmd.op == elg_pkg::DP_SETOK)
                                     || (cmd.op == elg_pkg::DP_SETERR));
            if (issue)
            begin
                dst_reg <= cmd.dst;
                case (cmd.op)
                    elg_pkg::DP_LOAD:
                    begin
                        ok_reg  <= 1'b0;
                        err_reg <= 1'b0;
                    end
                    elg_pkg::DP_SETOK:  ok_reg  <= (x_reg == y_reg);
                    elg_pkg::DP_SETERR: err_reg <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue && (cmd.op == elg_pkg::DP_LOAD))
        begin
            msg_reg    <= item.plain_value[W-1:0];
            k_reg      <= item.ephemeral_nonce[W-1:0];
            gam_reg    <= item.first_part_in[W-1:0];
            del_reg    <= item.second_part_in[W-1:0];
            first_reg  <= '0;
            second_reg <= '0;
            rec_reg    <= '0;
        end
        if (issue && (cmd.op == elg_pkg::DP_POWINIT))
        begin
            // a modulus of zero or one leaves every power at zero
            acc_reg <= (p_reg <= W'(1)) ? '0 : W'(1);
            e_reg   <= opnd_a;
        end
        if (issue && (cmd.op == elg_pkg::DP_ESHIFT))
        begin
            e_reg <= {e_reg[W-2:0], 1'b0};
        end
        if (div_done)
        begin
            quo_reg <= div_quo;
        end
        if (wr_en)
        begin
            case (wr_sel)
                elg_pkg::SEL_R0:     r0_reg     <= wr_val;
                elg_pkg::SEL_R1:     r1_reg     <= wr_val;
                elg_pkg::SEL_T0:     t0_reg     <= wr_val;
                elg_pkg::SEL_T1:     t1_reg     <= wr_val;
                elg_pkg::SEL_X:      x_reg      <= wr_val;
                elg_pkg::SEL_Y:      y_reg      <= wr_val;
                elg_pkg::SEL_ACC:    acc_reg    <= wr_val;
                elg_pkg::SEL_BAS:    bas_reg    <= wr_val;
                elg_pkg::SEL_FIRST:  first_reg  <= wr_val;
                elg_pkg::SEL_SECOND: second_reg <= wr_val;
                elg_pkg::SEL_REC:    rec_reg    <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        status.done    = quick_done_reg | mul_done | div_done;
        status.e_msb   = e_reg[W-1];
        status.r1_zero = (r1_reg == '0);
        status.r0_ne1  = (r0_reg != W'(1));
        status.q_lt2   = (q_reg < W'(2));
        status.gam_bad = (gam_reg == '0) || (gam_reg >= p_reg);
    end

    always_comb
    begin
        result.first_part_out  = elg_pkg::DATA_BITS'(first_reg);
        result.second_part_out = elg_pkg::DATA_BITS'(second_reg);
        result.recovered_value = elg_pkg::DATA_BITS'(rec_reg);
        result.signature_ok    = ok_reg;
        result.nonce_error     = err_reg;
    end

endmodule

// ----- src/elg_ctrl.sv -----
module elg_ctrl #(
    parameter int W = elg_pkg::WORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  elg_pkg::mode_t   mode,
    input  elg_pkg::status_t status,
    output elg_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    localparam int BW = $clog2(W);

    elg_pkg::state_t             state_reg, state_next;
    logic [elg_pkg::PC_BITS-1:0] pc_reg, pc_next;
    logic [BW-1:0]               bit_reg, bit_next;
    logic                        done_reg, done_next;
    elg_pkg::uinst_t             ui;
    logic                        cond_hit;

    assign ui = elg_pkg::ucode(pc_reg);

    always_comb
    begin
        case (ui.cond)
            elg_pkg::C_ALWAYS:  cond_hit = 1'b1;
            elg_pkg::C_R1_ZERO: cond_hit = status.r1_zero;
            elg_pkg::C_R0_NE1:  cond_hit = status.r0_ne1;
            elg_pkg::C_Q_LT2:   cond_hit = status.q_lt2;
            elg_pkg::C_GAM_BAD: cond_hit = status.gam_bad;
            default:            cond_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= elg_pkg::S_IDLE;
            pc_reg    <= '0;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            bit_reg   <= bit_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        cmd        = '{go: 1'b0, op: elg_pkg::DP_NOP, a: elg_pkg::SEL_ZERO,
                       b: elg_pkg::SEL_ZERO, modsel: elg_pkg::MOD_P,
                       dst: elg_pkg::SEL_ZERO};
        case (state_reg)
            elg_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.go     = 1'b1;
                    cmd.op     = elg_pkg::DP_LOAD;
                    pc_next    = elg_pkg::entry_pc(mode);
                    state_next = elg_pkg::S_FETCH;
                end
            end
            elg_pkg::S_FETCH:
            begin
                case (ui.kind)
                    elg_pkg::UK_OP:
                    begin
                        cmd        = '{go: 1'b1, op: ui.op, a: ui.a, b: ui.b,
                                       modsel: ui.modsel, dst: ui.dst};
                        pc_next    = pc_reg + 1'b1;
                        state_next = elg_pkg::S_WAIT;
                    end
                    elg_pkg::UK_BR:
                    begin
                        pc_next = cond_hit ? ui.target : (pc_reg + 1'b1);
                    end
                    elg_pkg::UK_POW:
                    begin
                        // reduce the base mod p into BAS
                        cmd        = '{go: 1'b1, op: elg_pkg::DP_DIV, a: ui.a,
                                       b: elg_pkg::SEL_P, modsel: elg_pkg::MOD_P,
                                       dst: elg_pkg::SEL_BAS};
                        state_next = elg_pkg::S_PW_RED;
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = elg_pkg::S_IDLE;
                    end
                endcase
            end
            elg_pkg::S_WAIT:
            begin
                if (status.done)
                begin
                    state_next = elg_pkg::S_FETCH;
                end
            end
            elg_pkg::S_PW_RED:
            begin
                if (status.done)
                begin
                    state_next = elg_pkg::S_PW_INIT;
                end
            end
            elg_pkg::S_PW_INIT:
            begin
                cmd.go     = 1'b1;
                cmd.op     = elg_pkg::DP_POWINIT;
                cmd.a      = ui.b;
                bit_next   = '0;
                state_next = elg_pkg::S_PW_SQ;
            end
            elg_pkg::S_PW_SQ:
            begin
                cmd        = '{go: 1'b1, op: elg_pkg::DP_MUL, a: elg_pkg::SEL_ACC,
                               b: elg_pkg::SEL_ACC, modsel: elg_pkg::MOD_P,
                               dst: elg_pkg::SEL_ACC};
                state_next = elg_pkg::S_PW_SQW;
            end
            elg_pkg::S_PW_SQW:
            begin
                if (status.done)
                begin
                    state_next = status.e_msb ? elg_pkg::S_PW_ML : elg_pkg::S_PW_SH;
                end
            end
            elg_pkg::S_PW_ML:
            begin
                cmd        = '{go: 1'b1, op: elg_pkg::DP_MUL, a: elg_pkg::SEL_ACC,
                               b: elg_pkg::SEL_BAS, modsel: elg_pkg::MOD_P,
                               dst: elg_pkg::SEL_ACC};
                state_next = elg_pkg::S_PW_MLW;
            end
            elg_pkg::S_PW_MLW:
            begin
                if (status.done)
                begin
                    state_next = elg_pkg::S_PW_SH;
                end
            end
            elg_pkg::S_PW_SH:
            begin
                cmd.go = 1'b1;
                cmd.op = elg_pkg::DP_ESHIFT;
                if (bit_reg == BW'(W - 1))
                begin
                    state_next = elg_pkg::S_PW_MV;
                end
                else
                begin
                    bit_next   = bit_reg + 1'b1;
                    state_next = elg_pkg::S_PW_SQ;
                end
            end
            elg_pkg::S_PW_MV:
            begin
                cmd.go     = 1'b1;
                cmd.op     = elg_pkg::DP_MOV;
                cmd.a      = elg_pkg::SEL_ACC;
                cmd.dst    = ui.dst;
                pc_next    = pc_reg + 1'b1;
                state_next = elg_pkg::S_WAIT;
            end
            default:
            begin
                state_next = elg_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != elg_pkg::S_IDLE);
    assign done = done_reg;

endmodule

// ----- src/elgamal_crypto_engine.sv -----
// channel  | handshake               | payload
// ---------+-------------------------+--------------------------------
// item     | start, busy             | item   (elg_pkg::item_t)
// result   | done (one-cycle strobe) | result (elg_pkg::result_t)
// config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// One item at a time. A modular multiply runs on the shared double-and-add
// unit; a reduction or division on the restoring divider. A power costs
// WORD_BITS squarings plus one multiply per set exponent bit; a rejected nonce
// or gamma ends an item early, and verify takes three powers.
// Reset (rst_n low, asynchronous) restores the key set p=3, g=2, beta=1, a=1.
// done holds for exactly one cycle; the receiver cannot stall it.
module elgamal_crypto_engine #(
    parameter int WORD_BITS = elg_pkg::WORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  elg_pkg::item_t                     item,
    output logic                               busy,
    output logic                               done,
    output elg_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [elg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [elg_pkg::DATA_BITS-1:0]      cfg_data
);

    elg_pkg::cmd_t    cmd;
    elg_pkg::status_t status;

    assign cfg_ready = ~busy;

    elg_ctrl #(.W(WORD_BITS)) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (item.mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    elg_datapath #(.W(WORD_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

// ----- src/elg_checker.sv -----
module elg_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input elg_pkg::result_t result,
    input logic             cfg_valid,
    input logic             cfg_ready
);

    // an accepted transfer always starts work
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // busy drops only together with a result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.signature_ok && result.nonce_error))
        else $error("verify and sign flags both set");

    // key writes land only between items
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> !busy)
        else $error("configuration transfer while busy");

endmodule

bind elgamal_crypto_engine elg_checker u_elg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ----- test/elgamal_crypto_engine_tb.sv -----
module elgamal_crypto_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GAP_MAX    = 12;
    localparam int STALL_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;

    typedef logic [63:0] word_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    elg_pkg::item_t                     item;
    logic                               busy;
    logic                               done;
    elg_pkg::result_t                   result;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [elg_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [elg_pkg::DATA_BITS-1:0]      cfg_data;

    // key set as the testbench sees it
    word_t key_p;
    word_t key_g;
    word_t key_beta;
    word_t key_a;

    elg_pkg::item_t   pending_items[$];
    elg_pkg::result_t expected_results[$];
    int      mismatches = 0;
    int      gap_left;
    int      stall_cycles;

    elgamal_crypto_engine uut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic word_t mod_mul(word_t x, word_t y, word_t m);
        logic [127:0] prod;
        if (m == 0)
            return 0;
        prod = {64'd0, x % m} * {64'd0, y % m};
        return word_t'(prod % {64'd0, m});
    endfunction

    function automatic word_t mod_sub(word_t x, word_t y, word_t m);
        if (x >= y)
            return x - y;
        return x + (m - y);
    endfunction

    function automatic word_t mod_pow(word_t base, word_t e, word_t m);
        word_t acc;
        if (m <= 1)
            return 0;
        acc = 1;
        base = base % m;
        for (int i = 63; i >= 0; i--)
        begin
            acc = mod_mul(acc, acc, m);
            if (e[i])
                acc = mod_mul(acc, base, m);
        end
        return acc;
    endfunction

    // extended Euclid; ok low when k has no inverse mod m
    function automatic logic nonce_inverse(word_t k, word_t m, output word_t inv);
        word_t r0, r1, t0, t1, quo, nr, nt;
        inv = 0;
        if (m < 2)
            return 1'b0;
        r0 = m;
        r1 = k % m;
        t0 = 0;
        t1 = 1;
        while (r1 != 0)
        begin
            quo = r0 / r1;
            nr = r0 - quo * r1;
            nt = mod_sub(t0, mod_mul(quo, t1, m), m);
            r0 = r1;
            r1 = nr;
            t0 = t1;
            t1 = nt;
        end
        if (r0 != 1)
            return 1'b0;
        inv = t0;
        return 1'b1;
    endfunction

    function automatic elg_pkg::result_t elgamal_outcome(elg_pkg::item_t it);
        elg_pkg::result_t r;
        word_t   q, ar, e, kinv, g1, s;
        r = '0;
        q = key_p - 1;
        case (it.mode)
            elg_pkg::MODE_ENCRYPT:
            begin
                r.first_part_out  = mod_pow(key_g, it.ephemeral_nonce, key_p);
                r.second_part_out = mod_mul(it.plain_value,
                                            mod_pow(key_beta, it.ephemeral_nonce, key_p),
                                            key_p);
            end
            elg_pkg::MODE_DECRYPT:
            begin
                ar = (q == 0) ? 64'd0 : key_a % q;
                e = q - ar;
                r.recovered_value = mod_mul(mod_pow(it.first_part_in, e, key_p),
                                            it.second_part_in, key_p);
            end
            elg_pkg::MODE_SIGN:
            begin
                if (nonce_inverse(it.ephemeral_nonce, q, kinv))
                begin
                    g1 = mod_pow(key_g, it.ephemeral_nonce, key_p);
                    s = mod_mul(key_a, g1, q);
                    r.first_part_out  = g1;
                    r.second_part_out = mod_mul(mod_sub(it.plain_value % q, s, q), kinv, q);
                end
                else
                    r.nonce_error = 1'b1;
            end
            default:
            begin
                if (it.first_part_in != 0 && it.first_part_in < key_p)
                    r.signature_ok =
                        (mod_mul(mod_pow(key_beta, it.first_part_in, key_p),
                                 mod_pow(it.first_part_in, it.second_part_in, key_p),
                                 key_p) == mod_pow(key_g, it.plain_value, key_p));
            end
        endcase
        return r;
    endfunction

    // driver: one transfer per item, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            item     <= '0;
            gap_left <= 0;
        end
        else if (start && busy)
        begin
            // hold until accepted
        end
        else
        begin
            if (start)
                expected_results.push_back(elgamal_outcome(item));
            if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() != 0)
            begin
                item     <= pending_items.pop_front();
                start    <= 1'b1;
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, GAP_MAX);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                elg_pkg::result_t want;
                want = expected_results.pop_front();
                if (result.first_part_out !== want.first_part_out
                    || result.second_part_out !== want.second_part_out
                    || result.recovered_value !== want.recovered_value
                    || result.signature_ok !== want.signature_ok
                    || result.nonce_error !== want.nonce_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: first %h/%h second %h/%h rec %h/%h ok %b/%b err %b/%b",
                                 want.first_part_out, result.first_part_out,
                                 want.second_part_out, result.second_part_out,
                                 want.recovered_value, result.recovered_value,
                                 want.signature_ok, result.signature_ok,
                                 want.nonce_error, result.nonce_error);
                end
            end
        end
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [elg_pkg::CFG_INDEX_BITS-1:0] idx, word_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            elg_pkg::CFG_MODULUS_P:   key_p = value;
            elg_pkg::CFG_GENERATOR_G: key_g = value;
            elg_pkg::CFG_PUBLIC_BETA: key_beta = value;
            default:                  key_a = value;
        endcase
    endtask

    task automatic load_keys(word_t p, word_t g, word_t beta, word_t a);
        write_reg(elg_pkg::CFG_MODULUS_P, p);
        write_reg(elg_pkg::CFG_GENERATOR_G, g);
        write_reg(elg_pkg::CFG_PUBLIC_BETA, beta);
        write_reg(elg_pkg::CFG_PRIVATE_EXPONENT, a);
    endtask

    // pick a key pair over prime p with beta = g^a
    task automatic load_prime_keys(word_t p);
        word_t g, a;
        g = 1 + rand_word() % (p - 1);
        a = ($urandom_range(0, 4) == 0) ? rand_word() : 1 + rand_word() % (p - 2);
        load_keys(p, g, mod_pow(g, a, p), a);
    endtask

    task automatic queue_item(elg_pkg::mode_t m, word_t msg, word_t k, word_t gam,
                              word_t del);
        elg_pkg::item_t it;
        it.mode            = m;
        it.plain_value     = msg;
        it.ephemeral_nonce = k;
        it.first_part_in   = gam;
        it.second_part_in  = del;
        pending_items.push_back(it);
    endtask

    // sample on the falling edge, clear of the driver's updates
    task automatic drain();
        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(int count);
        elg_pkg::result_t r;
        elg_pkg::item_t   it;
        word_t   msg, k;
        for (int n = 0; n < count; n++)
        begin
            msg = rand_word();
            k = rand_word();
            case ($urandom_range(0, 9))
                0, 1: queue_item(elg_pkg::mode_t'($urandom_range(0, 3)), msg, k,
                                 rand_word(), rand_word());
                2, 3: queue_item(elg_pkg::MODE_ENCRYPT, msg, k, rand_word(), rand_word());
                4, 5:
                begin
                    // encrypt then decrypt the ciphertext
                    msg = msg % key_p;
                    queue_item(elg_pkg::MODE_ENCRYPT, msg, k, 0, 0);
                    it = pending_items[$];
                    r = elgamal_outcome(it);
                    queue_item(elg_pkg::MODE_DECRYPT, 0, 0, r.first_part_out,
                               r.second_part_out);
                end
                6, 7, 8:
                begin
                    // sign then verify, sometimes with a spoilt signature
                    k[0] = ($urandom_range(0, 5) != 0);
                    queue_item(elg_pkg::MODE_SIGN, msg, k, 0, 0);
                    it = pending_items[$];
                    r = elgamal_outcome(it);
                    if ($urandom_range(0, 3) == 0)
                        r.second_part_out ^= 64'd1 << $urandom_range(0, 63);
                    queue_item(elg_pkg::MODE_VERIFY, msg, 0, r.first_part_out,
                               r.second_part_out);
                end
                default: queue_item(elg_pkg::MODE_DECRYPT, msg, k, rand_word(), rand_word());
            endcase
        end
        drain();
    endtask

    initial
    begin
        word_t primes[6];
        primes = '{64'd5, 64'd23, 64'd467, 64'd4294967291, 64'd2147483647,
                   64'hFFFFFFFFFFFFFFC5};
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        key_p = 3;
        key_g = 2;
        key_beta = 1;
        key_a = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset key set: every operation, nonce and gamma extremes
        queue_item(elg_pkg::MODE_ENCRYPT, '1, '1, 0, 0);
        queue_item(elg_pkg::MODE_ENCRYPT, 0, 0, 0, 0);
        queue_item(elg_pkg::MODE_DECRYPT, 0, 0, '1, '1);
        queue_item(elg_pkg::MODE_SIGN, 64'd7, 64'd1, 0, 0);
        queue_item(elg_pkg::MODE_SIGN, '1, 64'd2, 0, 0);
        queue_item(elg_pkg::MODE_VERIFY, 64'd1, 0, 0, 64'd3);
        queue_item(elg_pkg::MODE_VERIFY, 64'd1, 0, 64'd3, 64'd3);
        queue_item(elg_pkg::MODE_VERIFY, 64'd1, 0, 64'd2, 64'd1);
        drain();

        // largest 64-bit prime, private exponent beyond p-1
        load_keys(64'hFFFFFFFFFFFFFFC5, '1, '1, '1);
        queue_item(elg_pkg::MODE_ENCRYPT, '1, '1, '1, '1);
        queue_item(elg_pkg::MODE_DECRYPT, '1, '1, '1, '1);
        queue_item(elg_pkg::MODE_SIGN, '1, '1, 0, 0);
        queue_item(elg_pkg::MODE_SIGN, '1, 64'd4, 0, 0);
        queue_item(elg_pkg::MODE_VERIFY, '1, 0, 64'hFFFFFFFFFFFFFFC4, '1);
        queue_item(elg_pkg::MODE_VERIFY, '1, 0, '1, '1);
        drain();

        // zero modulus
        load_keys(0, 64'd5, 64'd7, 64'd9);
        queue_item(elg_pkg::MODE_ENCRYPT, 64'd3, 64'd5, 0, 0);
        queue_item(elg_pkg::MODE_DECRYPT, 0, 0, 64'd5, 64'd6);
        queue_item(elg_pkg::MODE_SIGN, 64'd11, 64'd3, 0, 0);
        queue_item(elg_pkg::MODE_VERIFY, 64'd2, 0, 64'd1, 64'd1);
        drain();

        // modulus one and two: q below two
        load_keys(64'd1, 64'd1, 64'd1, 64'd1);
        queue_item(elg_pkg::MODE_ENCRYPT, 64'd3, 64'd5, 0, 0);
        queue_item(elg_pkg::MODE_SIGN, 64'd3, 64'd5, 0, 0);
        queue_item(elg_pkg::MODE_DECRYPT, 0, 0, 64'd5, 64'd6);
        drain();
        load_keys(64'd2, 64'd1, 64'd1, 64'd1);
        queue_item(elg_pkg::MODE_SIGN, 64'd3, 64'd1, 0, 0);
        queue_item(elg_pkg::MODE_VERIFY, 64'd3, 0, 64'd1, 64'd1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            load_prime_keys(primes[ph]);
            random_phase(10);
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
